/* hw/rtl/h2r_pkg.sv */
`default_nettype none

package h2r_pkg;

   // Channel word: CHANNEL_MAX stands for one.
   localparam int CHANNEL_BITS = 16;
   localparam int HUE_BITS     = 16;

   // Hue in Q9.7 degrees: one turn is 360 * 128.
   localparam int HUE_TURN     = 46080;
   localparam int HUE_SIXTH    = HUE_TURN / 6;
   localparam int HUE_THIRD    = HUE_TURN / 3;
   localparam int HUE_POS_BITS = HUE_BITS + 1;

   // Interpolation weight runs 0..HUE_SIXTH inclusive.
   localparam int WEIGHT_BITS  = $clog2(HUE_SIXTH + 1);

   localparam int PROD_BITS    = 2 * CHANNEL_BITS;
   localparam int LERP_BITS    = CHANNEL_BITS + WEIGHT_BITS;

   // HUE_SIXTH = SIXTH_ODD << SIXTH_SHIFT; divide by the odd part through a reciprocal.
   localparam int SIXTH_SHIFT  = 9;
   localparam int SIXTH_ODD    = HUE_SIXTH >> SIXTH_SHIFT;
   localparam int HALF_SIXTH   = HUE_SIXTH / 2;
   localparam int QUOT_BITS    = LERP_BITS - SIXTH_SHIFT;
   localparam int RECIP_SHIFT  = CHANNEL_BITS + 8;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) / SIXTH_ODD) + 64'd1;
   localparam int RECIP_BITS   = CHANNEL_BITS + 5;
   localparam int SCALED_BITS  = QUOT_BITS + RECIP_BITS;

   // Rounding term for the divide by CHANNEL_MAX.
   localparam longint unsigned ROUND_HALF = (64'd1 << (CHANNEL_BITS - 1)) - 64'd1;

   // Queue between front and back; depth must be a power of two.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_COUNT = 3;

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [HUE_BITS-1:0]     hue_type;
   typedef logic [HUE_POS_BITS-1:0] hue_pos_type;
   typedef logic [WEIGHT_BITS-1:0]  weight_type;

   localparam chan_type    CHANNEL_MAX = '1;
   localparam hue_pos_type POS_TURN    = HUE_POS_BITS'(HUE_TURN);
   localparam hue_pos_type POS_THIRD   = HUE_POS_BITS'(HUE_THIRD);
   localparam hue_pos_type POS_SIXTH   = HUE_POS_BITS'(HUE_SIXTH);
   localparam hue_pos_type POS_HALF    = HUE_POS_BITS'(3 * HUE_SIXTH);
   localparam hue_pos_type POS_FALL    = HUE_POS_BITS'(4 * HUE_SIXTH);

   // One classified pixel as it waits in the queue.
   typedef struct packed {
      logic [PROD_BITS-1:0]       prod;
      chan_type                   light;
      chan_type                   sat;
      weight_type [CH_COUNT-1:0]  weight;
   } entry_type;

   // Wrap a hue position into one turn and map it onto the ramp weight:
   // zero gives p, HUE_SIXTH gives q, anything between blends the two.
   function automatic weight_type hue_weight(input hue_pos_type pos);
      hue_pos_type x;
      weight_type  w;
      x = (pos >= POS_TURN) ? pos - POS_TURN : pos;
      if (x < POS_SIXTH) begin
         w = WEIGHT_BITS'(x);
      end else if (x < POS_HALF) begin
         w = WEIGHT_BITS'(POS_SIXTH);
      end else if (x < POS_FALL) begin
         w = WEIGHT_BITS'(POS_FALL - x);
      end else begin
         w = '0;
      end
      return w;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/h2r_req_if.sv */
`default_nettype none

interface h2r_req_if;
   logic                 valid;
   logic                 ready;
   h2r_pkg::hue_type     hue_angle;
   h2r_pkg::chan_type    saturation;
   h2r_pkg::chan_type    lightness;

   modport source (output valid, output hue_angle, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue_angle, input saturation, input lightness,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/h2r_rsp_if.sv */
`default_nettype none

interface h2r_rsp_if;
   logic                 valid;
   logic                 ready;
   h2r_pkg::chan_type    red;
   h2r_pkg::chan_type    green;
   h2r_pkg::chan_type    blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

/* hw/rtl/h2r_front.sv */
`default_nettype none

module h2r_front (
   input  wire logic            clock,
   input  wire logic            reset,
   h2r_req_if.sink              req_chan,
   output logic                 push,
   output h2r_pkg::entry_type   push_entry,
   input  wire logic            queue_full
);

   logic                 valid_ff;
   logic                 valid_in;
   h2r_pkg::entry_type   entry_ff;
   h2r_pkg::entry_type   entry_in;
   h2r_pkg::hue_type     hue_wrap;
   h2r_pkg::hue_pos_type hue_pos;
   logic                 advance;

   assign advance        = !valid_ff || !queue_full;
   assign req_chan.ready = advance;
   assign push           = valid_ff && !queue_full;
   assign push_entry     = entry_ff;
   assign valid_in       = advance ? req_chan.valid : valid_ff;

   // Fold the hue into one turn, then classify each channel's offset position.
   always_comb begin
      hue_wrap = (req_chan.hue_angle >= h2r_pkg::HUE_BITS'(h2r_pkg::HUE_TURN))
               ? req_chan.hue_angle - h2r_pkg::HUE_BITS'(h2r_pkg::HUE_TURN)
               : req_chan.hue_angle;
      hue_pos  = {1'b0, hue_wrap};
      entry_in.prod  = h2r_pkg::PROD_BITS'(req_chan.lightness)
                     * h2r_pkg::PROD_BITS'(req_chan.saturation);
      entry_in.light = req_chan.lightness;
      entry_in.sat   = req_chan.saturation;
      entry_in.weight[h2r_pkg::CH_RED]   = h2r_pkg::hue_weight(hue_pos + h2r_pkg::POS_THIRD);
      entry_in.weight[h2r_pkg::CH_GREEN] = h2r_pkg::hue_weight(hue_pos);
      entry_in.weight[h2r_pkg::CH_BLUE]  =
         h2r_pkg::hue_weight(hue_pos + h2r_pkg::POS_THIRD + h2r_pkg::POS_THIRD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_chan.valid) begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/h2r_queue.sv */
`default_nettype none

module h2r_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire h2r_pkg::entry_type   push_entry,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      head_valid,
   output h2r_pkg::entry_type        head_entry
);

   h2r_pkg::entry_type                   slot_ff [h2r_pkg::QUEUE_DEPTH];
   logic [h2r_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [h2r_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_in;
   logic [h2r_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [h2r_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_in;
   logic [h2r_pkg::QUEUE_PTR_BITS:0]     count_ff;
   logic [h2r_pkg::QUEUE_PTR_BITS:0]     count_in;

   assign full       = count_ff == (h2r_pkg::QUEUE_PTR_BITS + 1)'(h2r_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (h2r_pkg::QUEUE_PTR_BITS + 1)'(h2r_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty queue");

   a_count_rise: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow a lone push");

endmodule

`default_nettype wire

/* hw/rtl/h2r_back.sv */
`default_nettype none

module h2r_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  wire h2r_pkg::entry_type   head_entry,
   output logic                      pop,
   h2r_rsp_if.source                 rsp_chan
);

   localparam int CB = h2r_pkg::CHANNEL_BITS;
   localparam int NC = h2r_pkg::CH_COUNT;

   logic advance;

   // stage valids
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic s4_valid_ff;
   logic rsp_valid_ff;

   // stage 1: L*S/M
   h2r_pkg::chan_type                s1_ls_ff;
   h2r_pkg::chan_type                s1_ls_in;
   h2r_pkg::chan_type                s1_light_ff;
   h2r_pkg::chan_type                s1_sat_ff;
   h2r_pkg::weight_type [NC-1:0]     s1_weight_ff;
   logic [h2r_pkg::PROD_BITS:0]      rnd_sum;
   logic [h2r_pkg::PROD_BITS:0]      fold_sum;

   // stage 2: p and q - p
   h2r_pkg::chan_type                s2_p_ff;
   h2r_pkg::chan_type                s2_p_in;
   h2r_pkg::chan_type                s2_span_ff;
   h2r_pkg::chan_type                s2_span_in;
   h2r_pkg::weight_type [NC-1:0]     s2_weight_ff;
   logic [CB:0]                      twice_l;
   logic                             dark;
   logic [CB+1:0]                    q_raw;
   h2r_pkg::chan_type                q_sat;
   logic [CB:0]                      p_raw;

   // stage 3: (q - p) * weight
   h2r_pkg::chan_type                s3_p_ff;
   logic [h2r_pkg::LERP_BITS-1:0]    s3_lerp_ff [NC];
   logic [h2r_pkg::LERP_BITS-1:0]    s3_lerp_in [NC];

   // stage 4: divide by a sixth through the reciprocal
   h2r_pkg::chan_type                s4_p_ff;
   logic [h2r_pkg::SCALED_BITS-1:0]  s4_scaled_ff [NC];
   logic [h2r_pkg::SCALED_BITS-1:0]  s4_scaled_in [NC];
   logic [h2r_pkg::LERP_BITS-1:0]    rounded [NC];
   logic [h2r_pkg::QUOT_BITS-1:0]    quot [NC];

   // output register
   h2r_pkg::chan_type                rsp_ff [NC];
   h2r_pkg::chan_type                rsp_in [NC];
   logic [CB:0]                      sum [NC];

   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign pop     = advance && head_valid;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = rsp_ff[h2r_pkg::CH_RED];
   assign rsp_chan.green = rsp_ff[h2r_pkg::CH_GREEN];
   assign rsp_chan.blue  = rsp_ff[h2r_pkg::CH_BLUE];

   // Round to nearest and divide by 2^CB - 1: x / M = (x + (x >> CB) + 1) >> CB for x < 2^(2CB).
   always_comb begin
      rnd_sum  = {1'b0, head_entry.prod} + (h2r_pkg::PROD_BITS + 1)'(h2r_pkg::ROUND_HALF);
      fold_sum = rnd_sum + (rnd_sum >> CB) + 1'b1;
      s1_ls_in = CB'(fold_sum >> CB);
   end

   // q on both branches, then p = 2L - q, each clamped to 0..M.
   always_comb begin
      twice_l = {s1_light_ff, 1'b0};
      dark    = twice_l < {1'b0, h2r_pkg::CHANNEL_MAX};
      if (dark) begin
         q_raw = {2'b00, s1_light_ff} + {2'b00, s1_ls_ff};
      end else begin
         q_raw = {2'b00, s1_light_ff} + {2'b00, s1_sat_ff} - {2'b00, s1_ls_ff};
      end
      q_sat = (q_raw > {2'b00, h2r_pkg::CHANNEL_MAX}) ? h2r_pkg::CHANNEL_MAX : q_raw[CB-1:0];
      p_raw = (twice_l >= {1'b0, q_sat}) ? twice_l - {1'b0, q_sat} : '0;
      s2_p_in    = (p_raw > {1'b0, h2r_pkg::CHANNEL_MAX}) ? h2r_pkg::CHANNEL_MAX : p_raw[CB-1:0];
      s2_span_in = q_sat - s2_p_in;
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         s3_lerp_in[c] = h2r_pkg::LERP_BITS'(s2_span_ff) * h2r_pkg::LERP_BITS'(s2_weight_ff[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         rounded[c]      = s3_lerp_ff[c] + h2r_pkg::LERP_BITS'(h2r_pkg::HALF_SIXTH);
         quot[c]         = h2r_pkg::QUOT_BITS'(rounded[c] >> h2r_pkg::SIXTH_SHIFT);
         s4_scaled_in[c] = h2r_pkg::SCALED_BITS'(quot[c]) * h2r_pkg::SCALED_BITS'(h2r_pkg::RECIP);
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         sum[c]    = {1'b0, s4_p_ff} + (CB + 1)'(s4_scaled_ff[c] >> h2r_pkg::RECIP_SHIFT);
         rsp_in[c] = (sum[c] > {1'b0, h2r_pkg::CHANNEL_MAX}) ? h2r_pkg::CHANNEL_MAX : sum[c][CB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= head_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ls_ff     <= s1_ls_in;
         s1_light_ff  <= head_entry.light;
         s1_sat_ff    <= head_entry.sat;
         s1_weight_ff <= head_entry.weight;
         s2_p_ff      <= s2_p_in;
         s2_span_ff   <= s2_span_in;
         s2_weight_ff <= s1_weight_ff;
         s3_p_ff      <= s2_p_ff;
         s4_p_ff      <= s3_p_ff;
         for (int c = 0; c < NC; c++) begin
            s3_lerp_ff[c]   <= s3_lerp_in[c];
            s4_scaled_ff[c] <= s4_scaled_in[c];
            rsp_ff[c]       <= rsp_in[c];
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/hsl_to_rgb_converter.sv */
// HSL to RGB pixel converter. A request carries hue in Q9.7 degrees (a hue of a full turn
// or more wraps) with saturation and lightness as unsigned fractions where all ones means
// one; the response carries red, green and blue in the same form, one response for every
// request, in order. The block keeps no state between pixels and takes one request every
// clock until the queue fills: the front stage accepts while the response register is still
// occupied, and a four-entry queue lets the front keep accepting while the back pipeline is
// held. With no back-pressure a request passes from the front register into the queue, from
// the queue into the first of five back stages, and on through the back stages to the
// response register. On the way lie the registered multipliers, L*S in the front and two
// per channel in the back for the hue ramp blend and its divide by a sixth of a turn.
`default_nettype none

module hsl_to_rgb_converter (
   input  wire logic   clock,
   input  wire logic   reset,
   h2r_req_if.sink     req_chan,
   h2r_rsp_if.source   rsp_chan
);

   logic                 push;
   h2r_pkg::entry_type   push_entry;
   logic                 queue_full;
   logic                 pop;
   logic                 head_valid;
   h2r_pkg::entry_type   head_entry;

   // Front: wrap the hue, place each channel on the ramp, start L*S.
   h2r_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // Decouple the front from stalls on the response side.
   h2r_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Back: L*S/M, q and p, then the blended ramp for each channel; advance whenever the
   // response register is free or being taken.
   h2r_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire
